@@ design/fmac_pkg.sv @@
// Shared types and constants for the FIR filter multiply-accumulate unit.
// Depends on nothing; imported by the top level and by its checker.
`timescale 1ns / 1ps

package fmac_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int IDX_W    = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 48;

  // Request kinds carried on req_type.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

@@ design/fir_filter_mac_unit.sv @@
// Direct-form FIR filter built around one shared multiply-accumulate unit.
// After a sample word is accepted, the unit walks the taps with one coefficient read and
// one delay-line read per tap, lets the read and multiply stages drain, and then hands
// the sum to the output register; an earlier result word still stalled there delays it.
// Input stays stalled until the handover. A coefficient write gives no result. Reset is
// synchronous, active high; after it a clearing pass zeroes both RAMs and stalls input.
`timescale 1ns / 1ps

module fir_filter_mac_unit
  import fmac_pkg::*;
#(
  parameter int TAPS = 256
) (
  input  logic                clk,
  input  logic                rst,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [IDX_W-1:0]    coef_index,
  input  logic [COEF_W-1:0]   coef_value,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ACC_W-1:0]    filtered_out
);

  localparam int AW = $clog2(TAPS);
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  // S_CLEAR sweeps both RAMs after reset. S_MAC issues one tap read per cycle,
  // S_DRAIN lets the read and multiply stages empty, and S_DONE hands the sum
  // to the output register once that register is free.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t        state;
  logic [AW-1:0] cnt;      // Clear address, then tap number being issued.
  logic [AW-1:0] pos;      // Delay-line slot of the tap being issued.
  logic [AW-1:0] wp;       // Slot that receives the next sample.
  logic          rd_v;     // RAM read data is a live tap.
  logic          prod_v;   // Product register holds a live tap.
  prod_t         prod;
  acc_t          acc;

  logic          in_take;
  logic          take_sample;
  logic          take_coef;
  logic          coef_ok;
  logic          out_free;

  logic          dly_we;
  logic [AW-1:0] dly_waddr;
  sample_t       dly_wdata;
  sample_t       dly_rdata;
  logic          cf_we;
  logic [AW-1:0] cf_waddr;
  coef_t         cf_wdata;
  coef_t         cf_rdata;

  assign in_stall    = (state != S_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign take_sample = in_take && (req_type == REQ_SAMPLE);
  assign take_coef   = in_take && (req_type == REQ_COEF);
  // Writes to taps the filter does not have are dropped.
  assign coef_ok     = (32'(coef_index) < 32'(TAPS));
  // The output register can take a new word at this edge.
  assign out_free    = !out_valid || !out_stall;

  // RAM port steering. Writes happen only while clearing or at acceptance, and
  // reads only while walking taps, so the two never touch the same entry at once.
  always_comb begin
    if (state == S_CLEAR) begin
      dly_we    = 1'b1;
      dly_waddr = cnt;
      dly_wdata = '0;
      cf_we     = 1'b1;
      cf_waddr  = cnt;
      cf_wdata  = '0;
    end else begin
      dly_we    = take_sample;
      dly_waddr = wp;
      dly_wdata = sample_t'(sample_in);
      cf_we     = take_coef && coef_ok;
      cf_waddr  = AW'(coef_index);
      cf_wdata  = coef_t'(coef_value);
    end
  end

  fmac_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .raddr (pos),
    .rdata (dly_rdata)
  );

  fmac_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (cnt),
    .rdata (cf_rdata)
  );

  // Control, the multiply-accumulate pipeline and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      pos       <= '0;
      wp        <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The multiplier and adder run every cycle; the valid bits gate them.
      rd_v   <= (state == S_MAC);
      prod_v <= rd_v;
      prod   <= cf_rdata * dly_rdata;
      if (prod_v) begin
        acc <= acc + ACC_W'(prod);
      end

      // The output register fills in S_DONE and empties once its word is taken.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (take_sample) begin
            // Tap 0 is the sample stored at this edge; walk backward from it.
            acc   <= '0;
            cnt   <= '0;
            pos   <= wp;
            wp    <= (wp == LAST) ? '0 : wp + 1'b1;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          pos <= (pos == '0) ? LAST : pos - 1'b1;
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !prod_v) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            filtered_out <= acc;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

@@ design/fmac_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// The read data is registered, so it appears in the cycle after the address.
`timescale 1ns / 1ps

module fmac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/fmac_checker.sv @@
// Port-level checker for the FIR filter multiply-accumulate unit, with its bind.
// Depends on fmac_pkg and on the port list of fir_filter_mac_unit.
`timescale 1ns / 1ps

module fmac_checker
  import fmac_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                req_type,
  input logic [SAMPLE_W-1:0] sample_in,
  input logic [IDX_W-1:0]    coef_index,
  input logic [COEF_W-1:0]   coef_value,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ACC_W-1:0]    filtered_out
);

  // The clearing pass keeps the input stalled right after reset.
  a_clear_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during clearing pass");

  // A sample word occupies the unit, so the next word must wait.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_SAMPLE) |=> in_stall)
    else $error("unit took a word while a sample was in flight");

  // A coefficient write never produces a result word.
  a_coef_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_COEF && !out_valid) |=> !out_valid)
    else $error("coefficient write produced a result");

  // A result only appears at the end of a busy period.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(filtered_out)))
    else $error("stalled result word changed");

endmodule

bind fir_filter_mac_unit fmac_checker u_fmac_checker (.*);
